/* sv/rgp_pkg.sv */
package rgp_pkg;

    // Field widths
    localparam int RANGE_BITS = 16;
    localparam int ANGLE_BITS = 16;
    localparam int INDEX_BITS = 12;
    localparam int XY_BITS    = RANGE_BITS + 1;
    localparam int CFG_W      = (RANGE_BITS > ANGLE_BITS) ? RANGE_BITS : ANGLE_BITS;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_MIN_RANGE  = 2'd0,
        REG_MAX_RANGE  = 2'd1,
        REG_ANGLE_STEP = 2'd2,
        REG_UNUSED     = 2'd3
    } cfg_addr_t;

    // CORDIC datapath: Q2.30 with headroom, 32-bit binary angle
    localparam int CW              = 33;
    localparam int CORDIC_STEPS    = 18;
    localparam int STEPS_PER_STAGE = 2;
    localparam int CORDIC_STAGES   = CORDIC_STEPS / STEPS_PER_STAGE;
    localparam int STEP_W          = $clog2(CORDIC_STEPS);
    localparam int CORDIC_GAIN_Q30 = 652032874;
    localparam int Q15_MAX         = 32767;
    localparam int PROD_W          = XY_BITS + 16;

    localparam logic signed [CW-1:0] ATAN_TBL [CORDIC_STEPS] = '{
        CW'(536870912), CW'(316933406), CW'(167458907), CW'(85004756),
        CW'(42667331),  CW'(21354465),  CW'(10679838),  CW'(5340245),
        CW'(2670163),   CW'(1335087),   CW'(667544),    CW'(333772),
        CW'(166886),    CW'(83443),     CW'(41722),     CW'(20861),
        CW'(10430),     CW'(5215)
    };

    // Quarter turn the residual angle is referred to
    typedef enum logic [1:0] {
        QUAD_0   = 2'd0,
        QUAD_90  = 2'd1,
        QUAD_180 = 2'd2,
        QUAD_270 = 2'd3
    } quad_t;

    typedef logic signed [15:0] trig_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } cordic_t;

    // Payload that rides along the pipeline
    typedef struct packed {
        logic [RANGE_BITS-1:0] range_mm;
        logic [INDEX_BITS-1:0] index;
    } side_t;

    // One micro-rotation toward z = 0
    function automatic cordic_t cordic_step(cordic_t v, logic [STEP_W-1:0] i);
        cordic_t              r;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        dx = $signed(v.y) >>> i;
        dy = $signed(v.x) >>> i;
        if (!v.z[CW-1])
        begin
            r.x = v.x - dx;
            r.y = v.y + dy;
            r.z = v.z - ATAN_TBL[i];
        end
        else
        begin
            r.x = v.x + dx;
            r.y = v.y - dy;
            r.z = v.z + ATAN_TBL[i];
        end
        return r;
    endfunction

    // Q2.30 to Q1.15, round half up, symmetric saturation
    function automatic trig_t to_q15(logic signed [CW-1:0] v);
        logic signed [CW-1:0] t;
        t = (v + CW'(16384)) >>> 15;
        if (t > CW'(Q15_MAX))
            return trig_t'(Q15_MAX);
        else if (t < -CW'(Q15_MAX))
            return -trig_t'(Q15_MAX);
        else
            return t[15:0];
    endfunction

endpackage

/* sv/rgp_if.sv */
interface rgp_sample_if;
    import rgp_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [RANGE_BITS-1:0] range_mm;
    logic                  range_invalid;
    logic [INDEX_BITS-1:0] sample_index;

    modport source (output valid, range_mm, range_invalid, sample_index, input ready);
    modport sink   (input valid, range_mm, range_invalid, sample_index, output ready);
endinterface

interface rgp_point_if;
    import rgp_pkg::*;

    logic                        valid;
    logic                        ready;
    logic signed [XY_BITS-1:0]   x_mm;
    logic signed [XY_BITS-1:0]   y_mm;
    logic [INDEX_BITS-1:0]       point_index;

    modport source (output valid, x_mm, y_mm, point_index, input ready);
    modport sink   (input valid, x_mm, y_mm, point_index, output ready);
endinterface

/* sv/rgp_front.sv */
module rgp_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           adv,
    input  logic                           accept,
    input  logic [rgp_pkg::RANGE_BITS-1:0] range_mm,
    input  logic                           range_invalid,
    input  logic [rgp_pkg::INDEX_BITS-1:0] sample_index,
    input  logic [rgp_pkg::RANGE_BITS-1:0] min_range,
    input  logic [rgp_pkg::RANGE_BITS-1:0] max_range,
    input  logic [rgp_pkg::ANGLE_BITS-1:0] angle_step,
    output logic                           vld,
    output rgp_pkg::side_t                 side,
    output logic [rgp_pkg::ANGLE_BITS-1:0] angle
);
    import rgp_pkg::*;

    logic                             keep;
    logic [INDEX_BITS+ANGLE_BITS-1:0] angle_full;
    logic                             vld_reg;
    side_t                            side_reg;
    logic [ANGLE_BITS-1:0]            angle_reg;

    // Range gate; dropped samples become bubbles
    assign keep = accept && !range_invalid
                  && (range_mm >= min_range) && (range_mm <= max_range);

    // Angle = index * step, wrapping per turn
    assign angle_full = (INDEX_BITS+ANGLE_BITS)'(sample_index)
                        * (INDEX_BITS+ANGLE_BITS)'(angle_step);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (adv)
            vld_reg <= keep;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg.range_mm <= range_mm;
            side_reg.index    <= sample_index;
            angle_reg         <= angle_full[ANGLE_BITS-1:0];
        end
    end

    assign vld   = vld_reg;
    assign side  = side_reg;
    assign angle = angle_reg;

endmodule

/* sv/rgp_cordic.sv */
module rgp_cordic (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           adv,
    input  logic                           vld_in,
    input  rgp_pkg::side_t                 side_in,
    input  logic [rgp_pkg::ANGLE_BITS-1:0] angle,
    output logic                           vld_out,
    output rgp_pkg::side_t                 side_out,
    output rgp_pkg::trig_t                 cos_q15,
    output rgp_pkg::trig_t                 sin_q15
);
    import rgp_pkg::*;

    logic [31:0]          a32;
    logic [31:0]          a_round;
    quad_t                quad0;
    logic [31:0]          resid;
    cordic_t              init;

    cordic_t              cs_reg   [CORDIC_STAGES];
    quad_t                quad_reg [CORDIC_STAGES];
    side_t                side_reg [CORDIC_STAGES];
    logic [CORDIC_STAGES-1:0] vld_reg;

    trig_t                cq;
    trig_t                sq;
    trig_t                cos_next;
    trig_t                sin_next;
    trig_t                cos_reg;
    trig_t                sin_reg;
    side_t                fin_side_reg;
    logic                 fin_vld_reg;

    // Split the angle into nearest quarter turn and signed residual
    assign a32     = {angle, {(32-ANGLE_BITS){1'b0}}};
    assign a_round = a32 + 32'h2000_0000;
    assign quad0   = quad_t'(a_round[31:30]);
    assign resid   = a32 - {a_round[31:30], 30'b0};
    assign init.x  = CW'(CORDIC_GAIN_Q30);
    assign init.y  = '0;
    assign init.z  = {{(CW-32){resid[31]}}, resid};

    // Rotation stages, two micro-rotations each
    for (genvar s = 0; s < CORDIC_STAGES; s++)
    begin : g_stage
        cordic_t v_in;
        cordic_t v_mid;
        cordic_t v_out;
        quad_t   q_in;
        side_t   sd_in;
        logic    vl_in;

        if (s == 0)
        begin : g_first
            assign v_in  = init;
            assign q_in  = quad0;
            assign sd_in = side_in;
            assign vl_in = vld_in;
        end
        else
        begin : g_next
            assign v_in  = cs_reg[s-1];
            assign q_in  = quad_reg[s-1];
            assign sd_in = side_reg[s-1];
            assign vl_in = vld_reg[s-1];
        end

        assign v_mid = cordic_step(v_in,  STEP_W'(STEPS_PER_STAGE*s));
        assign v_out = cordic_step(v_mid, STEP_W'(STEPS_PER_STAGE*s + 1));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else if (adv)
                vld_reg[s] <= vl_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                cs_reg[s]   <= v_out;
                quad_reg[s] <= q_in;
                side_reg[s] <= sd_in;
            end
        end
    end

    // Round to Q1.15 and fold the quarter turn back in
    assign cq = to_q15(cs_reg[CORDIC_STAGES-1].x);
    assign sq = to_q15(cs_reg[CORDIC_STAGES-1].y);

    always_comb
    begin
        case (quad_reg[CORDIC_STAGES-1])
            QUAD_0:
            begin
                cos_next = cq;
                sin_next = sq;
            end
            QUAD_90:
            begin
                cos_next = -sq;
                sin_next = cq;
            end
            QUAD_180:
            begin
                cos_next = -cq;
                sin_next = -sq;
            end
            QUAD_270:
            begin
                cos_next = sq;
                sin_next = -cq;
            end
            default:
            begin
                cos_next = cq;
                sin_next = sq;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fin_vld_reg <= 1'b0;
        else if (adv)
            fin_vld_reg <= vld_reg[CORDIC_STAGES-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cos_reg      <= cos_next;
            sin_reg      <= sin_next;
            fin_side_reg <= side_reg[CORDIC_STAGES-1];
        end
    end

    assign vld_out  = fin_vld_reg;
    assign side_out = fin_side_reg;
    assign cos_q15  = cos_reg;
    assign sin_q15  = sin_reg;

endmodule

/* sv/rgp_scale.sv */
module rgp_scale (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  logic                                vld_in,
    input  rgp_pkg::side_t                      side_in,
    input  rgp_pkg::trig_t                      cos_q15,
    input  rgp_pkg::trig_t                      sin_q15,
    output logic                                vld_out,
    output logic signed [rgp_pkg::XY_BITS-1:0]  x_mm,
    output logic signed [rgp_pkg::XY_BITS-1:0]  y_mm,
    output logic [rgp_pkg::INDEX_BITS-1:0]      index
);
    import rgp_pkg::*;

    logic signed [XY_BITS-1:0] r_s;
    logic signed [PROD_W-1:0]  px_next;
    logic signed [PROD_W-1:0]  py_next;
    logic signed [PROD_W-1:0]  px_reg;
    logic signed [PROD_W-1:0]  py_reg;
    logic signed [PROD_W-1:0]  rx;
    logic signed [PROD_W-1:0]  ry;
    logic                      vld_reg;
    logic [INDEX_BITS-1:0]     index_reg;

    // Range times cosine and sine
    assign r_s     = $signed({1'b0, side_in.range_mm});
    assign px_next = PROD_W'(r_s) * PROD_W'(cos_q15);
    assign py_next = PROD_W'(r_s) * PROD_W'(sin_q15);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (adv)
            vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg    <= px_next;
            py_reg    <= py_next;
            index_reg <= side_in.index;
        end
    end

    // Round half up to whole millimetres
    assign rx = (px_reg + PROD_W'(16384)) >>> 15;
    assign ry = (py_reg + PROD_W'(16384)) >>> 15;

    assign vld_out = vld_reg;
    assign x_mm    = rx[XY_BITS-1:0];
    assign y_mm    = ry[XY_BITS-1:0];
    assign index   = index_reg;

endmodule

/* sv/range_gated_polar_to_cartesian.sv */
// An accepted sample passes the front, CORDIC stage, rounding, multiply and output registers.
// Throughput: one sample per cycle; the 9-stage CORDIC pipeline and one
// multiply stage all advance together whenever the output register is free.
// Dropped samples (invalid or out of range) leave a bubble and no point.
// Reset: pipeline empty, min range 0, max range all ones, angle step 0.
module range_gated_polar_to_cartesian (
    input  logic                       clk,
    input  logic                       rst_n,
    rgp_sample_if.sink                 sample,
    rgp_point_if.source                point,
    input  logic                       cfg_we,
    input  rgp_pkg::cfg_addr_t         cfg_addr,
    input  logic [rgp_pkg::CFG_W-1:0]  cfg_wdata
);
    import rgp_pkg::*;

    logic [RANGE_BITS-1:0]     min_reg;
    logic [RANGE_BITS-1:0]     max_reg;
    logic [ANGLE_BITS-1:0]     step_reg;

    logic                      adv;
    logic                      accept;

    logic                      front_vld;
    side_t                     front_side;
    logic [ANGLE_BITS-1:0]     front_angle;

    logic                      cord_vld;
    side_t                     cord_side;
    trig_t                     cos_q15;
    trig_t                     sin_q15;

    logic                      sc_vld;
    logic signed [XY_BITS-1:0] sc_x;
    logic signed [XY_BITS-1:0] sc_y;
    logic [INDEX_BITS-1:0]     sc_index;

    logic                      out_vld_reg;
    logic signed [XY_BITS-1:0] out_x_reg;
    logic signed [XY_BITS-1:0] out_y_reg;
    logic [INDEX_BITS-1:0]     out_index_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg  <= '0;
            max_reg  <= '1;
            step_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_MIN_RANGE:  min_reg  <= cfg_wdata[RANGE_BITS-1:0];
                REG_MAX_RANGE:  max_reg  <= cfg_wdata[RANGE_BITS-1:0];
                REG_ANGLE_STEP: step_reg <= cfg_wdata[ANGLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Whole pipeline moves when the output register is empty or drained
    assign adv          = !out_vld_reg || point.ready;
    assign sample.ready = adv;
    assign accept       = sample.valid && adv;

    rgp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .accept        (accept),
        .range_mm      (sample.range_mm),
        .range_invalid (sample.range_invalid),
        .sample_index  (sample.sample_index),
        .min_range     (min_reg),
        .max_range     (max_reg),
        .angle_step    (step_reg),
        .vld           (front_vld),
        .side          (front_side),
        .angle         (front_angle)
    );

    rgp_cordic u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .vld_in   (front_vld),
        .side_in  (front_side),
        .angle    (front_angle),
        .vld_out  (cord_vld),
        .side_out (cord_side),
        .cos_q15  (cos_q15),
        .sin_q15  (sin_q15)
    );

    rgp_scale u_scale (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .vld_in  (cord_vld),
        .side_in (cord_side),
        .cos_q15 (cos_q15),
        .sin_q15 (sin_q15),
        .vld_out (sc_vld),
        .x_mm    (sc_x),
        .y_mm    (sc_y),
        .index   (sc_index)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= sc_vld;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_x_reg     <= sc_x;
            out_y_reg     <= sc_y;
            out_index_reg <= sc_index;
        end
    end

    assign point.valid       = out_vld_reg;
    assign point.x_mm        = out_x_reg;
    assign point.y_mm        = out_y_reg;
    assign point.point_index = out_index_reg;

    // A flagged sample never enters the pipeline
    a_drop_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && sample.ready && sample.range_invalid |=> !front_vld)
        else $error("invalid sample entered the pipeline");

    // A stall freezes the first stage
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !sample.ready |=> $stable(front_vld))
        else $error("pipeline moved during a stall");

    // Saturated trig never reaches the negative full scale
    a_trig_sat: assert property (@(posedge clk) disable iff (!rst_n)
        cord_vld |-> (cos_q15 != -trig_t'(Q15_MAX) - trig_t'(1))
                     && (sin_q15 != -trig_t'(Q15_MAX) - trig_t'(1)))
        else $error("trig value outside Q1.15 saturation range");

    // Coordinates stay within plus or minus the range full scale
    a_xy_bound: assert property (@(posedge clk) disable iff (!rst_n)
        point.valid |-> (point.x_mm != {1'b1, {RANGE_BITS{1'b0}}})
                        && (point.y_mm != {1'b1, {RANGE_BITS{1'b0}}}))
        else $error("coordinate overflow");

endmodule
